>>> hw/rtl/trd_pkg.sv
package trd_pkg;

  // Depth of the queue between the byte front end and the decode back end.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPRESSED   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PIXELS = 2'd2;

  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] PIXEL_BYTES_RESET = 3'd4;
  localparam logic [2:0] MAX_PIXEL_BYTES   = 3'd4;

  // Packet header layout.
  localparam int         HDR_RUN_BIT    = 7;
  localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;

  // One byte as it travels from the front end to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       run_bit;
    logic [7:0] count;
  } item_t;

  // Bytes per pixel actually used: zero acts as one, above four acts as four.
  function automatic logic [2:0] size_in_use(input logic [2:0] pixel_bytes);
    logic [2:0] n;
    n = pixel_bytes;
    if (pixel_bytes == 3'd0) begin
      n = 3'd1;
    end else if (pixel_bytes > MAX_PIXEL_BYTES) begin
      n = MAX_PIXEL_BYTES;
    end
    return n;
  endfunction

  // Exchange bytes 0 and 2 for pixels of three or four bytes.
  function automatic logic [31:0] swap_red_blue(input logic [31:0] px,
                                                input logic [2:0]  nbytes);
    logic [31:0] r;
    r = px;
    if (nbytes >= 3'd3) begin
      r = {px[31:24], px[7:0], px[15:8], px[23:16]};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/trd_front.sv
module trd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic                queue_ready,
  output logic                push,
  output trd_pkg::item_t      push_item
);

  logic           front_valid;
  logic           front_valid_next;
  trd_pkg::item_t front_item;
  logic           accept;

  assign byte_stall = front_valid && !queue_ready;
  assign accept     = byte_valid && !byte_stall;
  assign push       = front_valid && queue_ready;
  assign push_item  = front_item;

  always_comb begin
    front_valid_next = front_valid;
    if (accept) begin
      front_valid_next = 1'b1;
    end else if (push) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  // Classify the byte as a possible packet header on the way in.
  always_ff @(posedge clk) begin
    if (accept) begin
      front_item.data_byte  <= data_byte;
      front_item.first_byte <= first_byte;
      front_item.run_bit    <= data_byte[trd_pkg::HDR_RUN_BIT];
      front_item.count      <= {1'b0, data_byte[6:0] & trd_pkg::HDR_COUNT_MASK} + 8'd1;
    end
  end

endmodule

>>> hw/rtl/trd_queue.sv
module trd_queue #(
  parameter int DEPTH = trd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trd_pkg::item_t push_item,
  output logic           ready,
  input  logic           pop,
  output logic           head_valid,
  output trd_pkg::item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trd_pkg::item_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  assign ready      = count < CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/trd_back.sv
module trd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     pixel_bytes,
  input  logic           compressed,
  input  logic [31:0]    total_pixels,
  input  logic           head_valid,
  input  trd_pkg::item_t head,
  output logic           pop,
  output logic           pixel_valid,
  input  logic           pixel_stall,
  output logic [31:0]    pixel_value,
  output logic [7:0]     copies,
  output logic           last_pixel,
  output logic           overrun
);

  logic        expect_header;
  logic        run_packet;
  logic [7:0]  packet_left;
  logic [1:0]  byte_index;
  logic [31:0] pixel_shift;
  logic [31:0] pixels_done;

  logic        expect_header_next;
  logic        run_packet_next;
  logic [7:0]  packet_left_next;
  logic [1:0]  byte_index_next;
  logic [31:0] pixel_shift_next;
  logic [31:0] pixels_done_next;

  // State as seen by this byte, after a possible restart.
  logic        eh;
  logic        rp;
  logic [7:0]  pl;
  logic [1:0]  bi;
  logic [31:0] ps;
  logic [31:0] pd;

  logic [2:0]  nbytes;
  logic [31:0] remaining;
  logic        finished;
  logic        is_header;
  logic        pixel_end;
  logic        emit;
  logic [31:0] shifted;
  logic [7:0]  run_copies;
  logic        clamp;
  logic [7:0]  pl_dec;
  logic [7:0]  pl_new;
  logic [7:0]  copies_sel;
  logic        beyond;
  logic        last;

  always_comb begin
    eh = head.first_byte ? 1'b1  : expect_header;
    rp = head.first_byte ? 1'b0  : run_packet;
    pl = head.first_byte ? 8'd0  : packet_left;
    bi = head.first_byte ? 2'd0  : byte_index;
    ps = head.first_byte ? 32'd0 : pixel_shift;
    pd = head.first_byte ? 32'd0 : pixels_done;

    nbytes     = trd_pkg::size_in_use(pixel_bytes);
    remaining  = total_pixels - pd;
    finished   = pd >= total_pixels;
    is_header  = compressed && eh;
    pixel_end  = ({1'b0, bi} + 3'd1) >= nbytes;
    emit       = !finished && !is_header && pixel_end;
    shifted    = ps | ({24'd0, head.data_byte} << {bi, 3'b000});

    run_copies = (pl == 8'd0) ? 8'd1 : pl;
    clamp      = remaining < {24'd0, run_copies};
    pl_dec     = (pl != 8'd0) ? pl - 8'd1 : 8'd0;
    pl_new     = rp ? 8'd0 : pl_dec;

    copies_sel = 8'd1;
    beyond     = 1'b0;
    if (compressed) begin
      if (rp) begin
        copies_sel = clamp ? remaining[7:0] : run_copies;
        beyond     = clamp;
      end else begin
        beyond = pl_dec != 8'd0;
      end
    end
    last = {24'd0, copies_sel} == remaining;
  end

  always_comb begin
    expect_header_next = eh;
    run_packet_next    = rp;
    packet_left_next   = pl;
    byte_index_next    = bi;
    pixel_shift_next   = ps;
    pixels_done_next   = pd;
    if (!finished) begin
      if (is_header) begin
        run_packet_next    = head.run_bit;
        packet_left_next   = head.count;
        expect_header_next = 1'b0;
      end else if (!pixel_end) begin
        pixel_shift_next = shifted;
        byte_index_next  = bi + 2'd1;
      end else begin
        pixel_shift_next = 32'd0;
        byte_index_next  = 2'd0;
        pixels_done_next = pd + {24'd0, copies_sel};
        if (compressed) begin
          packet_left_next = pl_new;
          if (pl_new == 8'd0) begin
            expect_header_next = 1'b1;
          end
        end
      end
    end
  end

  // A byte that yields a pixel waits until the output register is free.
  assign pop = head_valid && (!emit || !pixel_valid || !pixel_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      packet_left   <= 8'd0;
      byte_index    <= 2'd0;
      pixel_shift   <= 32'd0;
      pixels_done   <= 32'd0;
      pixel_valid   <= 1'b0;
    end else begin
      if (pop) begin
        expect_header <= expect_header_next;
        run_packet    <= run_packet_next;
        packet_left   <= packet_left_next;
        byte_index    <= byte_index_next;
        pixel_shift   <= pixel_shift_next;
        pixels_done   <= pixels_done_next;
      end
      if (pop && emit) begin
        pixel_valid <= 1'b1;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      pixel_value <= trd_pkg::swap_red_blue(shifted, nbytes);
      copies      <= copies_sel;
      last_pixel  <= last;
      overrun     <= last && beyond;
    end
  end

endmodule

>>> hw/rtl/tga_rle_pixel_decoder_core.sv
// TGA run-length pixel decoder.
//
// Bytes of the image's pixel data enter on the byte channel (data_byte,
// first_byte; byte_valid and byte_stall). A transfer with first_byte set
// restarts decoding. Assembled pixels leave on the pixel channel
// (pixel_value, copies, last_pixel, overrun; pixel_valid and pixel_stall),
// each with a repeat count of 1 to 128 for a downstream replicator.
// The configuration port (cfg_write, cfg_index, cfg_data) sets the bytes per
// pixel, plain or run-length mode, and the pixel total of the image.
//
// One byte is taken per cycle while byte_stall is low. The transfer loads
// the front input register, the byte then moves into the queue, and the
// decode stage takes it from the head of the queue into the output
// register. The decode stage handles one byte per cycle while the output
// register is free, which sets the throughput. When the receiver stalls, the
// output register holds its pixel and the next byte that completes a pixel
// waits at the head of the queue; byte_stall rises once two more bytes sit
// behind it. Reset empties the pipeline, restores the registers to four
// bytes per pixel, plain mode and a total of zero, and awaits a header.
module tga_rle_pixel_decoder_core #(
  parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [trd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            first_byte,
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [31:0]                     pixel_value,
  output logic [7:0]                      copies,
  output logic                            last_pixel,
  output logic                            overrun
);

  logic [2:0]     pixel_bytes;
  logic           compressed;
  logic [31:0]    total_pixels;

  logic           queue_ready;
  logic           push;
  trd_pkg::item_t push_item;
  logic           pop;
  logic           head_valid;
  trd_pkg::item_t head;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes  <= trd_pkg::PIXEL_BYTES_RESET;
      compressed   <= 1'b0;
      total_pixels <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        trd_pkg::REG_PIXEL_BYTES:  pixel_bytes  <= cfg_data[2:0];
        trd_pkg::REG_COMPRESSED:   compressed   <= cfg_data[0];
        trd_pkg::REG_TOTAL_PIXELS: total_pixels <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Front end: takes each byte and tags it as a possible packet header.
  trd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .queue_ready (queue_ready),
    .push        (push),
    .push_item   (push_item)
  );

  // Short queue so the front keeps taking bytes while the back waits.
  trd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: packet state, pixel assembly, pixel count and output register.
  trd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pixel_bytes  (pixel_bytes),
    .compressed   (compressed),
    .total_pixels (total_pixels),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_value  (pixel_value),
    .copies       (copies),
    .last_pixel   (last_pixel),
    .overrun      (overrun)
  );

endmodule

>>> hw/rtl/trd_checker.sv
module trd_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic [31:0] pixel_value,
  input logic [7:0]  copies,
  input logic        last_pixel,
  input logic        overrun
);

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel output valid right after reset");

  // A stalled pixel stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_value) &&
                                   $stable(copies) && $stable(last_pixel))
    else $error("stalled pixel changed");

  // Repeat counts stay within one packet.
  a_copies: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> copies != 8'd0 && copies <= 8'd128)
    else $error("copy count out of range");

  // A clamped packet always ends the image.
  a_overrun_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && overrun |-> last_pixel)
    else $error("overrun without last pixel");

endmodule

bind tga_rle_pixel_decoder_core trd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel_value (pixel_value),
  .copies      (copies),
  .last_pixel  (last_pixel),
  .overrun     (overrun)
);

>>> tb/sv/tb_tga_rle_pixel_decoder_core.sv
`timescale 1ns / 100ps

// Testbench for the TGA run-length pixel decoder.
//
// Bytes go in on the byte channel and are decoded by a behavioral copy of the
// decoder that runs at the moment each byte transfer happens. Its pixels,
// or pixels given by directed rows, are queued. The pixel monitor compares
// each block pixel transfer, field by field, with the oldest queued pixel.
module tb_tga_rle_pixel_decoder_core;

  localparam int DRAIN_CYCLES   = 8;     // drains the three-stage pipeline
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer
  localparam int RANDOM_BYTES   = 250;   // decoded bytes per idling regime

  // One decoded pixel as it leaves the block.
  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  copies;
    logic        last;
    logic        ovr;
  } pixel_t;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  // How a directed byte is checked: by the decoder model, by a pixel typed
  // into the table, or by the rule that it yields no pixel at all.
  typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_NO_PIXEL, CHECK_GIVEN} check_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [trd_pkg::CFG_INDEX_W-1:0] index;
    logic [trd_pkg::CFG_DATA_W-1:0]  value;
    logic [7:0]                      data;
    logic                            is_first;
    check_t                          check;
    pixel_t                          pixel;
  } row_t;

  // Directed opening: an image with a total of zero, plain 4-byte pixels with
  // the red/blue exchange, the image-complete rule, the longest run on 1-byte
  // pixels with the largest total, a run clamped at the end of the image and
  // a literal packet that reaches past the end on 2-byte pixels.
  localparam int PLAN_ROWS = 34;
  localparam row_t PLAN [0:PLAN_ROWS-1] = '{
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h00, 1'b1, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_TOTAL_PIXELS, 32'd2, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_PIXEL_BYTES,  32'd4, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h11, 1'b1, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h22, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h33, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h44, 1'b0, CHECK_GIVEN,
      '{32'h4411_2233, 8'd1, 1'b0, 1'b0}},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hFF, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hFF, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hFF, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hFF, 1'b0, CHECK_GIVEN,
      '{32'hFFFF_FFFF, 8'd1, 1'b1, 1'b0}},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h5A, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_PIXEL_BYTES,  32'd1, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_COMPRESSED,   32'd1, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_TOTAL_PIXELS, 32'hFFFE_0001, 8'h00, 1'b0, CHECK_NO_PIXEL,
      '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hFF, 1'b1, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hAB, 1'b0, CHECK_GIVEN,
      '{32'h0000_00AB, 8'd128, 1'b0, 1'b0}},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h00, 1'b0, CHECK_GIVEN,
      '{32'h0000_0000, 8'd1, 1'b0, 1'b0}},
    '{ROW_WRITE, trd_pkg::REG_PIXEL_BYTES,  32'd3, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_TOTAL_PIXELS, 32'd5, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h81, 1'b1, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h01, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h02, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h03, 1'b0, CHECK_GIVEN,
      '{32'h0001_0203, 8'd2, 1'b0, 1'b0}},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h83, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h10, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h20, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h30, 1'b0, CHECK_GIVEN,
      '{32'h0010_2030, 8'd3, 1'b1, 1'b1}},
    '{ROW_WRITE, trd_pkg::REG_PIXEL_BYTES,  32'd2, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_WRITE, trd_pkg::REG_TOTAL_PIXELS, 32'd1, 8'h00, 1'b0, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'h01, 1'b1, CHECK_NO_PIXEL, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hCD, 1'b0, CHECK_PREDICTED, '0},
    '{ROW_BYTE,  trd_pkg::REG_PIXEL_BYTES,  32'd0, 8'hAB, 1'b0, CHECK_GIVEN,
      '{32'h0000_ABCD, 8'd1, 1'b1, 1'b1}}
  };

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [trd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            byte_valid;
  logic                            byte_stall;
  logic [7:0]                      data_byte;
  logic                            first_byte;
  logic                            pixel_valid;
  logic                            pixel_stall = 1'b0;
  logic [31:0]                     pixel_value;
  logic [7:0]                      copies;
  logic                            last_pixel;
  logic                            overrun;

  // Register copies held by the model.
  logic [2:0]  cfg_pixel_bytes;
  logic        cfg_compressed;
  logic [31:0] cfg_total;

  // Decoder state of the model.
  logic        st_expect_header;
  logic        st_run;
  logic [7:0]  st_left;
  logic [1:0]  st_index;
  logic [31:0] st_shift;
  logic [31:0] st_done;

  pixel_t pending_pixels[$];

  int tx_idle_pct;
  int rx_stall_pct = 0;
  int errors;
  int bytes_sent;
  int bytes_decoded;
  int pixels_checked;
  int settings_used;
  int idle_cycles;

  tga_rle_pixel_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_value (pixel_value),
    .copies      (copies),
    .last_pixel  (last_pixel),
    .overrun     (overrun)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random at the rate of the current regime.
  always @(negedge clk) begin
    pixel_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  // Behavioral decoder. It advances on one byte transfer and returns 1 when
  // that byte completes a pixel. A restart clears the decode state but keeps
  // the registers. Once the image total is reached, bytes change nothing.
  function automatic bit decode_byte(input logic [7:0] b, input logic is_first,
                                     output pixel_t px);
    int          size;
    logic [32:0] remaining;
    logic [32:0] count;
    logic        beyond;
    logic [31:0] word;
    px = '0;
    size = (cfg_pixel_bytes == 3'd0) ? 1 : (cfg_pixel_bytes > 3'd4) ? 4 : cfg_pixel_bytes;
    if (is_first) begin
      st_expect_header = 1'b1;
      st_run = 1'b0;
      st_left = '0;
      st_index = '0;
      st_shift = '0;
      st_done = '0;
    end
    if (st_done >= cfg_total) return 1'b0;
    remaining = {1'b0, cfg_total} - {1'b0, st_done};

    // A packet header only sets up the packet.
    if (cfg_compressed && st_expect_header) begin
      st_run = b[trd_pkg::HDR_RUN_BIT];
      st_left = {1'b0, b[6:0] & trd_pkg::HDR_COUNT_MASK} + 8'd1;
      st_expect_header = 1'b0;
      return 1'b0;
    end

    st_shift = st_shift | (32'(b) << (8 * st_index));
    if (int'(st_index) + 1 < size) begin
      st_index = st_index + 2'd1;
      return 1'b0;
    end
    word = st_shift;
    if (size >= 3) word = {st_shift[31:24], st_shift[7:0], st_shift[15:8], st_shift[23:16]};
    st_index = '0;
    st_shift = '0;

    count = 33'd1;
    beyond = 1'b0;
    if (cfg_compressed) begin
      if (st_run) begin
        count = {25'd0, st_left};
        if (count == 33'd0) count = 33'd1;
        if (count > remaining) begin
          beyond = 1'b1;
          count = remaining;
        end
        st_left = '0;
      end else begin
        if (st_left != 8'd0) st_left = st_left - 8'd1;
        beyond = (st_left != 8'd0);
      end
      if (st_left == 8'd0) st_expect_header = 1'b1;
    end

    st_done = st_done + count[31:0];
    px.value = word;
    px.copies = count[7:0];
    px.last = (st_done >= cfg_total);
    px.ovr = px.last && beyond;
    return 1'b1;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // Pixel monitor: every pixel transfer must match the oldest queued pixel.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pixel_valid && !pixel_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel %0h with no pixel expected", $time, pixel_value);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        report_field("pixel_value", want.value, pixel_value);
        report_field("copies", 32'(want.copies), 32'(copies));
        report_field("last_pixel", 32'(want.last), 32'(last_pixel));
        report_field("overrun", 32'(want.ovr), 32'(overrun));
        pixels_checked++;
      end
    end
  end

  // Watchdog: a correct run never goes this long without any transfer.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (pixel_valid && !pixel_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One byte transfer, preceded by random sender gaps. The payload is set at
  // the falling edge and held until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic is_first);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      byte_valid = 1'b0;
    end
    @(negedge clk);
    byte_valid = 1'b1;
    data_byte = b;
    first_byte = is_first;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  // Stop sending, let every queued pixel arrive, then give a byte that made
  // no pixel time to leave the pipeline.
  task automatic settle_pipeline();
    @(negedge clk);
    byte_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [trd_pkg::CFG_INDEX_W-1:0] index,
                                input logic [trd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (index)
      trd_pkg::REG_PIXEL_BYTES:  cfg_pixel_bytes = value[2:0];
      trd_pkg::REG_COMPRESSED:   cfg_compressed = value[0];
      trd_pkg::REG_TOTAL_PIXELS: cfg_total = value;
      default: ;
    endcase
  endtask

  // Picks a pixel total: mostly small images, with the extremes mixed in.
  function automatic logic [31:0] pick_total();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 32'd0;
    if (roll < 20) return 32'd1;
    if (roll < 28) return 32'hFFFE_0001;
    if (roll < 38) return $urandom_range(32'hFFFE_0001, 0);
    return $urandom_range(2, 60);
  endfunction

  // Picks a packet header: short packets mostly, long ones now and then.
  function automatic logic [7:0] pick_header();
    int roll;
    logic [6:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 75) len = 7'($urandom_range(0, 7));
    else len = 7'($urandom_range(8, 127));
    if (roll >= 97) return 8'($urandom_range(0, 255));
    return {1'($urandom_range(0, 1)), len};
  endfunction

  initial begin
    pixel_t px;
    bit     made;
    bit     is_first;
    bit     restart_pending;
    bit     ignored;
    logic [7:0] b;
    int     decoded;
    int     phase_left;
    int     tx_pcts[3];
    int     rx_pcts[3];

    tx_pcts = '{16, 73, 0};
    rx_pcts = '{73, 16, 0};
    errors = 0;
    bytes_sent = 0;
    bytes_decoded = 0;
    pixels_checked = 0;
    settings_used = 1;
    idle_cycles = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    byte_valid = 1'b0;
    data_byte = '0;
    first_byte = 1'b0;

    // Model state after reset: four-byte plain pixels, total of zero.
    cfg_pixel_bytes = trd_pkg::PIXEL_BYTES_RESET;
    cfg_compressed = 1'b0;
    cfg_total = '0;
    st_expect_header = 1'b1;
    st_run = 1'b0;
    st_left = '0;
    st_index = '0;
    st_shift = '0;
    st_done = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, walked under the first idling regime.
    tx_idle_pct = tx_pcts[0];
    rx_stall_pct = rx_pcts[0];
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (PLAN[r].kind == ROW_WRITE) begin
        // Registers change only once the pipeline is empty.
        settle_pipeline();
        write_register(PLAN[r].index, PLAN[r].value);
        settings_used++;
      end else begin
        send_byte(PLAN[r].data, PLAN[r].is_first);
        made = decode_byte(PLAN[r].data, PLAN[r].is_first, px);
        case (PLAN[r].check)
          CHECK_PREDICTED: if (made) pending_pixels.push_back(px);
          CHECK_GIVEN:     pending_pixels.push_back(PLAN[r].pixel);
          default: ;
        endcase
      end
    end

    // Random part: three idling regimes, each split into phases with their own
    // register setting. A phase does not always restart the image, so size and
    // mode also change in the middle of a pixel or a packet.
    for (int regime = 0; regime < 3; regime++) begin
      tx_idle_pct = tx_pcts[regime];
      rx_stall_pct = rx_pcts[regime];
      decoded = 0;
      phase_left = 0;
      restart_pending = 1'b0;
      while (decoded < RANDOM_BYTES) begin
        if (phase_left == 0) begin
          settle_pipeline();
          if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 99) < 80) begin
              write_register(trd_pkg::REG_PIXEL_BYTES, $urandom_range(1, 4));
            end else begin
              write_register(trd_pkg::REG_PIXEL_BYTES, $urandom_range(0, 7));
            end
          end
          if ($urandom_range(0, 99) < 60) begin
            write_register(trd_pkg::REG_COMPRESSED, $urandom_range(0, 1));
          end
          if ($urandom_range(0, 99) < 70) begin
            write_register(trd_pkg::REG_TOTAL_PIXELS, pick_total());
          end
          settings_used++;
          restart_pending = ($urandom_range(0, 99) < 70);
          phase_left = $urandom_range(20, 80);
        end else if ($urandom_range(0, 99) < 2) begin
          // Sender holds off until the block has delivered everything.
          settle_pipeline();
        end

        // Restart when asked, when the image is complete (mostly), and now
        // and then at a random point as noise.
        is_first = restart_pending || ($urandom_range(0, 99) < 3);
        if (!is_first && st_done >= cfg_total) is_first = ($urandom_range(0, 99) < 85);
        restart_pending = 1'b0;

        if (cfg_compressed && (is_first || st_expect_header)) b = pick_header();
        else b = 8'($urandom_range(0, 255));

        ignored = is_first ? (cfg_total == 32'd0) : (st_done >= cfg_total);
        send_byte(b, is_first);
        made = decode_byte(b, is_first, px);
        if (made) pending_pixels.push_back(px);
        if (!ignored) begin
          decoded++;
          bytes_decoded++;
        end
        phase_left--;
      end
    end

    settle_pipeline();

    $display("Run covered %0d byte transfers (%0d decoded) under %0d register settings,",
             bytes_sent, bytes_decoded, settings_used);
    $display("three idling regimes, and %0d pixel transfers compared.", pixels_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> tga_rle_pixel_decoder_core.f
hw/rtl/trd_pkg.sv
hw/rtl/trd_front.sv
hw/rtl/trd_queue.sv
hw/rtl/trd_back.sv
hw/rtl/tga_rle_pixel_decoder_core.sv
hw/rtl/trd_checker.sv
tb/sv/tb_tga_rle_pixel_decoder_core.sv
